// ===== sv/sha256_pkg.sv =====
// Shared types, round constants and initial hash values for the SHA-256 hasher.
// No dependencies; imported by sha256_core and sha256_message_hasher.
package sha256_pkg;

    typedef logic [31:0] word_t;

    // Sequencer of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_GO,
        ST_WAIT,
        ST_OUT
    } top_state_t;

    // Where the top level goes once a compression finishes
    typedef enum logic [1:0] {
        AFT_IDLE,
        AFT_PAD,
        AFT_ZERO,
        AFT_OUT
    } after_t;

    // Sequencer of the compression unit
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_ROUND,
        CS_ADD
    } core_state_t;

    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned ROUNDS      = 64;

    localparam logic [5:0] LAST_BYTE   = 6'd63;
    localparam logic [5:0] LEN_POS     = 6'd56;
    localparam logic [5:0] LAST_ROUND  = 6'd63;
    localparam logic [2:0] LAST_DIGEST = 3'd7;
    localparam logic [7:0] PAD_MARKER  = 8'h80;

    localparam word_t K_TABLE [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t H_INIT [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic word_t rotr(word_t x, int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

// ===== sv/sha256_core.sv =====
// SHA-256 compression unit: one round per cycle over a 16-word schedule window,
// then a feed-forward add into the eight hash words. Depends on sha256_pkg.
module sha256_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  sha256_pkg::core_ctrl_t ctrl,
    input  sha256_pkg::word_t    block_in [16],
    output sha256_pkg::word_t    hash_out [8],
    output sha256_pkg::core_stat_t stat
);
    import sha256_pkg::*;

    core_state_t state_reg, state_next;
    logic [5:0]  rnd_reg;
    word_t       hash_reg [HASH_WORDS];
    word_t       w_reg [BLOCK_WORDS];
    word_t       v_reg [HASH_WORDS];
    word_t       v_next [HASH_WORDS];
    word_t       w_new;
    word_t       big0, big1, ch, maj, t1, s0, s1;

    // Round datapath
    always_comb begin
        big1 = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1   = v_reg[7] + big1 + ch + K_TABLE[rnd_reg] + w_reg[0];
        big0 = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        v_next[7] = v_reg[6];
        v_next[6] = v_reg[5];
        v_next[5] = v_reg[4];
        v_next[4] = v_reg[3] + t1;
        v_next[3] = v_reg[2];
        v_next[2] = v_reg[1];
        v_next[1] = v_reg[0];
        v_next[0] = t1 + big0 + maj;
        s0    = rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
        s1    = rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE: begin
                if (ctrl.start) state_next = CS_ROUND;
            end
            CS_ROUND: begin
                if (rnd_reg == LAST_ROUND) state_next = CS_ADD;
            end
            CS_ADD: begin
                state_next = CS_IDLE;
            end
            default: state_next = CS_IDLE;
        endcase
    end

    always_comb begin
        stat.busy = (state_reg != CS_IDLE);
        stat.done = (state_reg == CS_ADD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= CS_IDLE;
            rnd_reg   <= '0;
            hash_reg  <= H_INIT;
        end else begin
            state_reg <= state_next;
            if (state_reg == CS_ROUND) begin
                rnd_reg <= rnd_reg + 6'd1;
            end else begin
                rnd_reg <= '0;
            end
            if (state_reg == CS_ADD) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    hash_reg[i] <= hash_reg[i] + v_reg[i];
                end
            end else if (state_reg == CS_IDLE && ctrl.init) begin
                hash_reg <= H_INIT;
            end
        end
    end

    // Working variables and schedule window
    always_ff @(posedge aclk) begin
        if (state_reg == CS_IDLE && ctrl.start) begin
            w_reg <= block_in;
            v_reg <= hash_reg;
        end else if (state_reg == CS_ROUND) begin
            v_reg <= v_next;
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[BLOCK_WORDS - 1] <= w_new;
        end
    end

    assign hash_out = hash_reg;

endmodule

// ===== sv/sha256_message_hasher.sv =====
// Top level of the SHA-256 byte-stream hasher: byte packing, padding, length
// count, digest output. Depends on sha256_pkg and sha256_core.
//
// Usage: each request on s_ carries one optional byte (s_has_byte) and an
// end-of-message flag. Bytes are packed big-endian into a 16-word block.
// The 64th byte of a block starts the compression unit, which runs one
// round per cycle; s_ready stays low through the start, the 64 rounds and
// the feed-forward add, so no byte is taken while a block is compressed.
// The round loop of the compression unit sets the throughput.
// On end of message the tail is padded and compressed once, or
// twice when fewer than nine bytes of room remain; then the eight digest
// words go out on m_, word 0 first, m_last_word on word 7. s_ready stays low
// while the digest is offered; a stalled m_ready holds the current word.
// After the last word is taken the hash, length and byte count return to
// their initial values. Reset (aresetn low, synchronous) does the same and
// drops any partial message.
module sha256_message_hasher (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_has_byte,
    input  logic        s_end_of_message,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_digest_word,
    output logic [2:0]  m_word_index,
    output logic        m_last_word
);
    import sha256_pkg::*;

    top_state_t state_reg, state_next;
    after_t     after_reg, after_next;
    logic [5:0]  pos_reg, pos_next;
    logic [60:0] len_reg, len_next;
    logic [2:0]  oidx_reg, oidx_next;
    word_t       block_reg [BLOCK_WORDS];
    word_t       block_next [BLOCK_WORDS];
    word_t       hash_w [HASH_WORDS];
    core_ctrl_t  core_ctrl;
    core_stat_t  core_stat;
    logic        s_req, m_req, full_blk;
    logic [1:0]  lane;
    logic [5:0]  bpos;

    assign s_req    = s_valid && s_ready;
    assign m_req    = m_valid && m_ready;
    assign full_blk = s_req && s_has_byte && (pos_reg == LAST_BYTE);
    assign lane     = ~pos_reg[1:0];

    sha256_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (core_ctrl),
        .block_in (block_reg),
        .hash_out (hash_w),
        .stat     (core_stat)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        after_next = after_reg;
        case (state_reg)
            ST_IDLE: begin
                if (full_blk) begin
                    state_next = ST_GO;
                    after_next = s_end_of_message ? AFT_PAD : AFT_IDLE;
                end else if (s_req && s_end_of_message) begin
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                state_next = ST_GO;
                after_next = (pos_reg >= LEN_POS) ? AFT_ZERO : AFT_OUT;
            end
            ST_ZERO: begin
                state_next = ST_GO;
                after_next = AFT_OUT;
            end
            ST_GO: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (core_stat.done) begin
                    case (after_reg)
                        AFT_IDLE: state_next = ST_IDLE;
                        AFT_PAD:  state_next = ST_PAD;
                        AFT_ZERO: state_next = ST_ZERO;
                        AFT_OUT:  state_next = ST_OUT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUT: begin
                if (m_req && oidx_reg == LAST_DIGEST) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Handshake and unit control
    always_comb begin
        s_ready        = (state_reg == ST_IDLE);
        m_valid        = (state_reg == ST_OUT);
        core_ctrl.start = (state_reg == ST_GO);
        core_ctrl.init  = (state_reg == ST_OUT) && m_req && (oidx_reg == LAST_DIGEST);
        m_digest_word  = hash_w[oidx_reg];
        m_word_index   = oidx_reg;
        m_last_word    = (oidx_reg == LAST_DIGEST);
    end

    // Counters and block store
    always_comb begin
        pos_next   = pos_reg;
        len_next   = len_reg;
        oidx_next  = oidx_reg;
        block_next = block_reg;
        bpos       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_req && s_has_byte) begin
                    block_next[pos_reg[5:2]][{lane, 3'b000} +: 8] = s_data_byte;
                    pos_next = pos_reg + 6'd1;
                    len_next = len_reg + 61'd1;
                end
            end
            ST_PAD: begin
                // marker at the current position, zeros after it
                for (int i = 0; i < BLOCK_WORDS; i++) begin
                    for (int j = 0; j < 4; j++) begin
                        bpos = 6'(4 * i + j);
                        if (bpos == pos_reg) begin
                            block_next[i][8 * (3 - j) +: 8] = PAD_MARKER;
                        end else if (bpos > pos_reg) begin
                            block_next[i][8 * (3 - j) +: 8] = 8'h00;
                        end
                    end
                end
                if (pos_reg < LEN_POS) begin
                    block_next[14] = len_reg[60:29];
                    block_next[15] = {len_reg[28:0], 3'b000};
                end
            end
            ST_ZERO: begin
                for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
                    block_next[i] = '0;
                end
                block_next[14] = len_reg[60:29];
                block_next[15] = {len_reg[28:0], 3'b000};
            end
            ST_OUT: begin
                if (m_req) begin
                    oidx_next = oidx_reg + 3'd1;
                    if (oidx_reg == LAST_DIGEST) begin
                        pos_next = '0;
                        len_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            after_reg <= AFT_IDLE;
            pos_reg   <= '0;
            len_reg   <= '0;
            oidx_reg  <= '0;
        end else begin
            state_reg <= state_next;
            after_reg <= after_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            oidx_reg  <= oidx_next;
        end
    end

    always_ff @(posedge aclk) begin
        block_reg <= block_next;
    end

`ifndef SYNTH
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input and digest channels open together");

    a_full_block_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        full_blk |=> !s_ready && !m_valid)
        else $error("full block did not start compression");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        core_stat.done |-> (state_reg == ST_WAIT))
        else $error("compression finished outside wait");

    a_end_reopens: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_req && m_last_word) |=> s_ready && pos_reg == 6'd0 && len_reg == 61'd0)
        else $error("state not cleared after digest");
`endif

endmodule
